/* rtl/ltfb_pkg.sv */
package ltfb_pkg;

	localparam int DISPLAY_WIDTH_DEF = 128;
	localparam int DISPLAY_PAGES_DEF = 8;
	localparam int GLYPH_COUNT = 59;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int CHAR_ADVANCE = 6;
	localparam int LINE_ADVANCE = 9;
	localparam int CMD_COUNT = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CMD_PAGE = 8'hB0;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [7:0] CMD_COL_LO = 8'h00;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_CURSOR = 3'd1,
		OP_CENTER = 3'd2,
		OP_CHAR = 3'd3,
		OP_HLINE = 3'd4,
		OP_FLUSH = 3'd5
	} op_t;

	// decoded work handed from front to back
	typedef enum logic [1:0] {
		JOB_CLEAR,
		JOB_DRAW,
		JOB_FLUSH
	} job_kind_t;

	// one draw job: a single span of columns x0..x1, each column gets an OR mask at a row
	typedef struct packed {
		job_kind_t kind;
		logic [8:0] x0;     // first column (may be off screen)
		logic [8:0] x1;     // last column, inclusive
		logic [8:0] y;      // top row of the pattern
		logic [5:0] glyph;  // glyph index; ignored for lines
		logic is_line;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_WRITE,
		ST_FLUSH_RD,
		ST_FLUSH_OUT
	} back_state_t;

	function automatic logic [7:0] glyph_col(input logic [5:0] idx, input logic [2:0] col);
		logic [39:0] g;
		begin
			case (idx)
				6'd0: g = 40'h0000000000; 6'd1: g = 40'h00005F0000; 6'd2: g = 40'h0007000700;
				6'd3: g = 40'h147F147F14; 6'd4: g = 40'h242A7F2A12; 6'd5: g = 40'h2313086462;
				6'd6: g = 40'h3649552250; 6'd7: g = 40'h0005030000; 6'd8: g = 40'h001C224100;
				6'd9: g = 40'h0041221C00; 6'd10: g = 40'h082A1C2A08; 6'd11: g = 40'h08083E0808;
				6'd12: g = 40'h0050300000; 6'd13: g = 40'h0808080808; 6'd14: g = 40'h0060600000;
				6'd15: g = 40'h2010080402; 6'd16: g = 40'h3E5149453E; 6'd17: g = 40'h00427F4000;
				6'd18: g = 40'h4261514946; 6'd19: g = 40'h2141454B31; 6'd20: g = 40'h1814127F10;
				6'd21: g = 40'h2745454539; 6'd22: g = 40'h3C4A494930; 6'd23: g = 40'h0171090503;
				6'd24: g = 40'h3649494936; 6'd25: g = 40'h064949291E; 6'd26: g = 40'h0036360000;
				6'd27: g = 40'h0056360000; 6'd28: g = 40'h0008142241; 6'd29: g = 40'h1414141414;
				6'd30: g = 40'h4122140800; 6'd31: g = 40'h0201510906; 6'd32: g = 40'h324979413E;
				6'd33: g = 40'h7E1111117E; 6'd34: g = 40'h7F49494936; 6'd35: g = 40'h3E41414122;
				6'd36: g = 40'h7F4141221C; 6'd37: g = 40'h7F49494941; 6'd38: g = 40'h7F09090101;
				6'd39: g = 40'h3E41415132; 6'd40: g = 40'h7F0808087F; 6'd41: g = 40'h00417F4100;
				6'd42: g = 40'h2040413F01; 6'd43: g = 40'h7F08142241; 6'd44: g = 40'h7F40404040;
				6'd45: g = 40'h7F0204027F; 6'd46: g = 40'h7F0408107F; 6'd47: g = 40'h3E4141413E;
				6'd48: g = 40'h7F09090906; 6'd49: g = 40'h3E4151215E; 6'd50: g = 40'h7F09192946;
				6'd51: g = 40'h4649494931; 6'd52: g = 40'h01017F0101; 6'd53: g = 40'h3F4040403F;
				6'd54: g = 40'h1F2040201F; 6'd55: g = 40'h7F2018207F; 6'd56: g = 40'h6314081463;
				6'd57: g = 40'h0304780403; 6'd58: g = 40'h6151494543;
				default: g = 40'h0;
			endcase
			case (col)
				3'd0: glyph_col = g[39:32];
				3'd1: glyph_col = g[31:24];
				3'd2: glyph_col = g[23:16];
				3'd3: glyph_col = g[15:8];
				3'd4: glyph_col = g[7:0];
				default: glyph_col = 8'h00;
			endcase
		end
	endfunction

endpackage

/* rtl/ltfb_front.sv */
// Decodes ops, owns the text cursor, turns drawing ops into jobs.
module ltfb_front #(
	parameter int DISPLAY_WIDTH = ltfb_pkg::DISPLAY_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] op,
	input  logic [6:0] x_pos,
	input  logic [5:0] y_pos,
	input  logic [6:0] x_end,
	input  logic [7:0] char_code,
	input  logic [7:0] text_length,
	output logic job_valid,
	input  logic job_ready,
	output ltfb_pkg::job_t job
);

	// 6 * 255 needs 11 bits
	localparam int CW = 11;
	localparam logic [CW-1:0] WIDTH_C = CW'(DISPLAY_WIDTH);

	logic [7:0] cursor_col_q, cursor_row_q;
	logic [7:0] code_up;
	logic [5:0] gidx;
	logic wrap;
	logic [7:0] col_eff, row_eff;
	logic [CW-1:0] len6;
	logic [8:0] row_sum, col_sum;
	logic fire;

	assign in_ready = job_ready;
	assign fire = in_valid && in_ready;

	always_comb begin
		code_up = (char_code >= 8'h61 && char_code <= 8'h7A) ? char_code - 8'd32 : char_code;
		gidx = (code_up >= 8'h20 && code_up <= 8'h5A) ? 6'(code_up - 8'h20) : 6'd0;
		wrap = (CW'(cursor_col_q) + CW'(ltfb_pkg::GLYPH_COLS)) > WIDTH_C;
		row_sum = 9'(cursor_row_q) + 9'(ltfb_pkg::LINE_ADVANCE);
		col_eff = wrap ? 8'd0 : cursor_col_q;
		row_eff = wrap ? (row_sum[8] ? 8'hFF : row_sum[7:0]) : cursor_row_q;
		col_sum = 9'(col_eff) + 9'(ltfb_pkg::CHAR_ADVANCE);
		len6 = CW'({text_length, 2'b00}) + CW'({text_length, 1'b0});
	end

	always_comb begin
		job_valid = 1'b0;
		job = '0;
		job.kind = ltfb_pkg::JOB_DRAW;
		case (op)
			ltfb_pkg::OP_CLEAR: begin
				job_valid = in_valid;
				job.kind = ltfb_pkg::JOB_CLEAR;
			end
			ltfb_pkg::OP_CHAR: begin
				job_valid = in_valid;
				job.x0 = 9'(col_eff);
				job.x1 = 9'(col_eff) + 9'(ltfb_pkg::GLYPH_COLS - 1);
				job.y = 9'(row_eff);
				job.glyph = gidx;
			end
			ltfb_pkg::OP_HLINE: begin
				job_valid = in_valid && (x_end >= x_pos);
				job.x0 = 9'(x_pos);
				job.x1 = 9'(x_end);
				job.y = 9'(y_pos);
				job.is_line = 1'b1;
			end
			ltfb_pkg::OP_FLUSH: begin
				job_valid = in_valid;
				job.kind = ltfb_pkg::JOB_FLUSH;
			end
			default: job_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else if (fire) begin
			case (op)
				ltfb_pkg::OP_CURSOR: begin
					cursor_col_q <= 8'(x_pos);
					cursor_row_q <= 8'(y_pos);
				end
				ltfb_pkg::OP_CENTER: begin
					cursor_col_q <= (len6 >= WIDTH_C) ? 8'd0 : 8'((WIDTH_C - len6) >> 1);
					cursor_row_q <= 8'(y_pos);
				end
				ltfb_pkg::OP_CHAR: begin
					cursor_col_q <= col_sum[8] ? 8'hFF : col_sum[7:0];
					cursor_row_q <= row_eff;
				end
				default: ;
			endcase
		end
	end

endmodule

/* rtl/ltfb_queue.sv */
// Small job FIFO between front and back.
module ltfb_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  ltfb_pkg::job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output ltfb_pkg::job_t rd_data
);

	ltfb_pkg::job_t mem_q [ltfb_pkg::QUEUE_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'(ltfb_pkg::QUEUE_DEPTH);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

/* rtl/ltfb_back.sv */
// Executes jobs on the page store: clear sweep, per-column read-modify-write, refresh bytes.
module ltfb_back #(
	parameter int DISPLAY_WIDTH = ltfb_pkg::DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_PAGES = ltfb_pkg::DISPLAY_PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  ltfb_pkg::job_t job,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] lcd_byte,
	output logic is_data,
	output logic frame_end
);

	localparam int DEPTH = DISPLAY_WIDTH * DISPLAY_PAGES;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(DISPLAY_PAGES);
	localparam int SPAN = DISPLAY_WIDTH + ltfb_pkg::CMD_COUNT;
	localparam int OW = $clog2(SPAN);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	ltfb_pkg::back_state_t state_q, state_d;
	ltfb_pkg::job_t job_q;
	logic [8:0] x_q;
	logic half_q;          // second page of a glyph that straddles two pages
	logic [AW-1:0] clr_q;
	logic [PW-1:0] page_q;
	logic [OW-1:0] off_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_data_q, out_end_q;

	logic [7:0] pat;
	logic [15:0] pat_sh;
	logic [8:0] row_pg;
	logic [7:0] mask;
	logic on_screen;
	logic [AW-1:0] wr_addr, fl_addr;
	logic wr_en, take_job, emit;

	always_comb begin
		pat = job_q.is_line ? 8'h01 : ltfb_pkg::glyph_col(job_q.glyph, 3'(x_q - job_q.x0));
		pat_sh = 16'(pat) << job_q.y[2:0];
		row_pg = (job_q.y >> 3) + 9'(half_q);
		mask = half_q ? pat_sh[15:8] : pat_sh[7:0];
		on_screen = (x_q < 9'(DISPLAY_WIDTH)) && (row_pg < 9'(DISPLAY_PAGES));
		wr_addr = AW'(row_pg) * AW'(DISPLAY_WIDTH) + AW'(x_q);
		fl_addr = AW'(page_q) * AW'(DISPLAY_WIDTH) + AW'(off_q - OW'(ltfb_pkg::CMD_COUNT));
	end

	assign job_ready = (state_q == ltfb_pkg::ST_IDLE) && !out_valid_q;
	assign take_job = job_valid && job_ready;
	assign emit = state_q == ltfb_pkg::ST_FLUSH_OUT;

	always_comb begin
		state_d = state_q;
		wr_en = 1'b0;
		case (state_q)
			ltfb_pkg::ST_IDLE: if (take_job) begin
				case (job.kind)
					ltfb_pkg::JOB_CLEAR: state_d = ltfb_pkg::ST_CLEAR;
					ltfb_pkg::JOB_FLUSH: state_d = ltfb_pkg::ST_FLUSH_RD;
					default: state_d = ltfb_pkg::ST_READ;
				endcase
			end
			ltfb_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				if (clr_q == AW'(DEPTH - 1)) state_d = ltfb_pkg::ST_IDLE;
			end
			ltfb_pkg::ST_READ: state_d = ltfb_pkg::ST_WRITE;
			ltfb_pkg::ST_WRITE: begin
				wr_en = on_screen && (mask != 8'h00);
				if (x_q == job_q.x1 && (half_q || job_q.is_line || job_q.y[2:0] <= 3'd1))
					state_d = ltfb_pkg::ST_IDLE;
				else
					state_d = ltfb_pkg::ST_READ;
			end
			ltfb_pkg::ST_FLUSH_RD: state_d = ltfb_pkg::ST_FLUSH_OUT;
			ltfb_pkg::ST_FLUSH_OUT: state_d = ltfb_pkg::ST_IDLE;
			default: state_d = ltfb_pkg::ST_IDLE;
		endcase
	end

	// 8-bit glyph columns (7 rows) spill into the next page unless y[2:0] <= 1
	always_ff @(posedge clk) begin
		rd_data_q <= mem[state_q == ltfb_pkg::ST_FLUSH_RD ? fl_addr : wr_addr];
		if (state_q == ltfb_pkg::ST_CLEAR) mem[clr_q] <= 8'h00;
		else if (wr_en) mem[wr_addr] <= rd_data_q | mask;
		if (take_job) job_q <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ltfb_pkg::ST_CLEAR;
			clr_q <= '0;
			x_q <= '0;
			half_q <= 1'b0;
			page_q <= '0;
			off_q <= '0;
			out_valid_q <= 1'b0;
			out_byte_q <= '0;
			out_data_q <= 1'b0;
			out_end_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ltfb_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (take_job) begin
				clr_q <= '0;
				x_q <= job.x0;
				half_q <= 1'b0;
			end else if (state_q == ltfb_pkg::ST_WRITE) begin
				if (x_q == job_q.x1 && !job_q.is_line && !half_q && job_q.y[2:0] > 3'd1) begin
					x_q <= job_q.x0;
					half_q <= 1'b1;
				end else begin
					x_q <= x_q + 9'd1;
				end
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (emit) begin
				out_valid_q <= 1'b1;
				out_end_q <= (page_q == PW'(DISPLAY_PAGES - 1)) && (off_q == OW'(SPAN - 1));
				out_data_q <= off_q >= OW'(ltfb_pkg::CMD_COUNT);
				case (off_q)
					OW'(0): out_byte_q <= ltfb_pkg::CMD_PAGE | 8'(page_q);
					OW'(1): out_byte_q <= ltfb_pkg::CMD_COL_HI;
					OW'(2): out_byte_q <= ltfb_pkg::CMD_COL_LO;
					default: out_byte_q <= rd_data_q;
				endcase
				if (off_q == OW'(SPAN - 1)) begin
					off_q <= '0;
					page_q <= (page_q == PW'(DISPLAY_PAGES - 1)) ? '0 : page_q + PW'(1);
				end else begin
					off_q <= off_q + OW'(1);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign lcd_byte = out_byte_q;
	assign is_data = out_data_q;
	assign frame_end = out_end_q;

endmodule

/* rtl/lcd_text_framebuffer_engine_top.sv */
// Text framebuffer engine for a page-organized monochrome panel.
// Input channel (s_axis_*): one beat is one op: clear, set cursor, centered
//   cursor, put char, horizontal line or flush tick.
// Output channel (m_axis_*): one beat per flush tick carrying the next byte of
//   the refresh sequence (per page: page command, two column commands, then
//   DISPLAY_WIDTH data bytes); tuser marks data vs command, tlast the frame end.
// The front decodes ops and updates the cursor in the accept cycle; drawing
// work passes through a two-entry job queue to the back, which owns the store.
// Back work per job: a char reads then writes each of its 5 columns, again
//   on the next page when the glyph straddles two pages; an hline reads then
//   writes each column; clear writes zero to every store byte; a flush reads
//   one byte in ST_FLUSH_RD, then registers it for tvalid in ST_FLUSH_OUT.
//   Cursor ops never reach the back. The single store port serializes this work.
// Reset: the store is swept to zero, all DISPLAY_WIDTH*DISPLAY_PAGES bytes
//   (1024 by default); ops queue up meanwhile, up to the queue depth.
// Stalls: a result waits in the output register; the back takes no new job
//   until it is taken, and the queue then fills and deasserts s_axis_tready.
module lcd_text_framebuffer_engine_top #(
	parameter int DISPLAY_WIDTH = ltfb_pkg::DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_PAGES = ltfb_pkg::DISPLAY_PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// op[2:0], x_pos[9:3], y_pos[15:10], x_end[22:16], char_code[30:23],
	// text_length[38:31], zero pad [39]
	input  logic [39:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// lcd_byte[7:0]
	output logic [7:0] m_axis_tdata,
	// is_data[0]
	output logic m_axis_tuser,
	output logic m_axis_tlast
);

	ltfb_pkg::job_t fj, bj;
	logic fv, fr, bv, br;

	ltfb_front #(.DISPLAY_WIDTH(DISPLAY_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.op(s_axis_tdata[2:0]), .x_pos(s_axis_tdata[9:3]), .y_pos(s_axis_tdata[15:10]),
		.x_end(s_axis_tdata[22:16]), .char_code(s_axis_tdata[30:23]),
		.text_length(s_axis_tdata[38:31]),
		.job_valid(fv), .job_ready(fr), .job(fj)
	);

	ltfb_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fv), .wr_ready(fr), .wr_data(fj),
		.rd_valid(bv), .rd_ready(br), .rd_data(bj)
	);

	ltfb_back #(.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_PAGES(DISPLAY_PAGES)) u_back (
		.clk, .arst_n,
		.job_valid(bv), .job_ready(br), .job(bj),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.lcd_byte(m_axis_tdata), .is_data(m_axis_tuser), .frame_end(m_axis_tlast)
	);

endmodule

/* rtl/ltfb_checker.sv */
module ltfb_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic m_axis_tuser,
	input logic m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("frame end on a command byte");

	a_cmd_page: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
		(m_axis_tdata[7:4] == 4'hB || m_axis_tdata == 8'h10 || m_axis_tdata == 8'h00))
		else $error("bad command byte");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("output valid out of reset");

endmodule

bind lcd_text_framebuffer_engine_top ltfb_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready,
	.m_axis_tdata, .m_axis_tuser, .m_axis_tlast
);
